>>> design/pidfd_pkg.sv
// Shared types, constants and fixed-point helpers of the filtered-derivative PID controller.
package pidfd_pkg;

  // Word geometry: signed Q16.16 words, filter weight in unsigned Q1.16
  localparam int DATA_WIDTH  = 32;
  localparam int FRAC_BITS   = 16;
  localparam int ALPHA_BITS  = 17;
  localparam int ALPHA_FRAC  = 16;
  localparam int WIDE_WIDTH  = 64;
  localparam int CFG_IDX_W   = 3;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [WIDE_WIDTH-1:0] wide_t;
  typedef logic        [ALPHA_BITS-1:0] alpha_t;

  localparam alpha_t ALPHA_ONE = alpha_t'(1) << ALPHA_FRAC;
  localparam wide_t  WIDE_MAX  = (wide_t'(1) <<< (DATA_WIDTH - 1)) - wide_t'(1);
  localparam wide_t  WIDE_MIN  = -WIDE_MAX - wide_t'(1);
  localparam data_t  DATA_MAX  = data_t'(WIDE_MAX);
  localparam data_t  DATA_MIN  = data_t'(WIDE_MIN);

  // Configuration register indices
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_FILT_WEIGHT = 3'd3,
    REG_OUT_UPPER   = 3'd4,
    REG_OUT_LOWER   = 3'd5,
    REG_INTEG_UPPER = 3'd6,
    REG_INTEG_LOWER = 3'd7
  } cfg_reg_e;

  // Datapath operations, one per cycle of an item's sequence; OP_SUM waits on output stall
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_MUL_P  = 3'd1,
    OP_MUL_I  = 3'd2,
    OP_MUL_D  = 3'd3,
    OP_MUL_A1 = 3'd4,
    OP_MUL_A2 = 3'd5,
    OP_FILT   = 3'd6,
    OP_SUM    = 3'd7
  } op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    op_e  op;
    logic take_in;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    data_t value;
    logic  hit;
  } clamp_t;

  // Saturate a wide signed value to the data range.
  function automatic data_t sat_wide(input wide_t v);
    data_t r;
    if (v > WIDE_MAX) begin
      r = DATA_MAX;
    end else if (v < WIDE_MIN) begin
      r = DATA_MIN;
    end else begin
      r = data_t'(v);
    end
    return r;
  endfunction

  // Saturating sum of two data words.
  function automatic data_t sat_add(input data_t a, input data_t b);
    return sat_wide(wide_t'(a) + wide_t'(b));
  endfunction

  // Saturating difference of two data words.
  function automatic data_t sat_sub(input data_t a, input data_t b);
    return sat_wide(wide_t'(a) - wide_t'(b));
  endfunction

  // Rescale a full product (floor) and saturate it.
  function automatic data_t fx_scale(input wide_t p);
    return sat_wide(p >>> FRAC_BITS);
  endfunction

  // Upper limit first, then lower, so crossed limits give the lower one.
  function automatic clamp_t clamp(input data_t v, input data_t hi, input data_t lo);
    clamp_t r;
    r.value = v;
    if (r.value > hi) begin
      r.value = hi;
    end
    if (r.value < lo) begin
      r.value = lo;
    end
    r.hit = (r.value != v);
    return r;
  endfunction

endpackage

>>> design/pidfd_ctrl.sv
// Sequencing controller of the filtered-derivative PID controller.
module pidfd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pidfd_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SUM
  } state_e;

  state_e          state_q;
  pidfd_pkg::op_e  op_q;
  logic            out_valid_q;
  logic            out_free;
  logic            take_in;
  logic            load_out;

  // Handshake decisions
  assign take_in    = (state_q == ST_IDLE) && in_valid_i;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load_out   = (state_q == ST_SUM) && out_free;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.op       = op_q;
  assign cmd_o.take_in  = take_in;
  assign cmd_o.load_out = load_out;

  // State, operation step and output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= pidfd_pkg::OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (take_in) begin
            state_q <= ST_RUN;
            op_q    <= pidfd_pkg::OP_MUL_P;
          end
        end
        ST_RUN: begin
          if (op_q == pidfd_pkg::OP_FILT) begin
            state_q <= ST_SUM;
            op_q    <= pidfd_pkg::OP_SUM;
          end else begin
            op_q <= pidfd_pkg::op_e'(3'(op_q) + 3'd1);
          end
        end
        ST_SUM: begin
          if (out_free) begin
            state_q <= ST_IDLE;
            op_q    <= pidfd_pkg::OP_NONE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          op_q    <= pidfd_pkg::OP_NONE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // An accepted word starts the multiply sequence in the next cycle.
  a_start_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_in |=> (state_q == ST_RUN) && (op_q == pidfd_pkg::OP_MUL_P))
    else $error("sequence did not start after accept");

  // Handing the result to the output register frees the block.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("controller not idle after result load");

  // A new output word only appears after the final step.
  a_valid_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_SUM))
    else $error("output valid raised outside final step");
`endif

endmodule

>>> design/pidfd_dp.sv
// Datapath of the filtered-derivative PID controller: registers, shared multiplier, state.
module pidfd_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pidfd_pkg::dp_cmd_t                   cmd_i,
  input  logic signed [pidfd_pkg::DATA_WIDTH-1:0] setpoint_i,
  input  logic signed [pidfd_pkg::DATA_WIDTH-1:0] measured_i,
  input  logic                                 cfg_we_i,
  input  logic [pidfd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pidfd_pkg::DATA_WIDTH-1:0]     cfg_data_i,
  output logic signed [pidfd_pkg::DATA_WIDTH-1:0] drive_o,
  output logic                                 drive_clamped_o,
  output logic                                 integ_clamped_o
);

  localparam int MUL_W  = pidfd_pkg::DATA_WIDTH + 1;
  localparam int APAD_W = MUL_W - pidfd_pkg::ALPHA_BITS;

  // Configuration registers
  pidfd_pkg::data_t  prop_gain_q, integ_gain_q, deriv_gain_q;
  pidfd_pkg::alpha_t filt_weight_q;
  pidfd_pkg::data_t  out_upper_q, out_lower_q, integ_upper_q, integ_lower_q;

  // Loop state carried between words
  pidfd_pkg::data_t  last_err_q, integ_q, filt_q;

  // Per-word working registers
  pidfd_pkg::data_t  err_q, diff_q, prop_q, ud_q, s1_q;
  pidfd_pkg::wide_t  prod_q, acc_q;
  logic              ihit_q;

  // Output register
  pidfd_pkg::data_t  drive_q;
  logic              dhit_q, ihit_out_q;

  logic signed [MUL_W-1:0]     mul_a, mul_b;
  logic signed [2*MUL_W-1:0]   mul_full;
  pidfd_pkg::alpha_t           alpha, alpha_rest;
  pidfd_pkg::clamp_t           integ_clamp, drive_clamp;

  // Filter weight above one acts as one
  assign alpha      = (filt_weight_q > pidfd_pkg::ALPHA_ONE) ? pidfd_pkg::ALPHA_ONE
                                                             : filt_weight_q;
  assign alpha_rest = pidfd_pkg::ALPHA_ONE - alpha;

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      pidfd_pkg::OP_MUL_P: begin
        mul_a = MUL_W'(prop_gain_q);
        mul_b = MUL_W'(err_q);
      end
      pidfd_pkg::OP_MUL_I: begin
        mul_a = MUL_W'(integ_gain_q);
        mul_b = MUL_W'(err_q);
      end
      pidfd_pkg::OP_MUL_D: begin
        mul_a = MUL_W'(deriv_gain_q);
        mul_b = MUL_W'(diff_q);
      end
      pidfd_pkg::OP_MUL_A1: begin
        mul_a = signed'({{APAD_W{1'b0}}, alpha_rest});
        mul_b = MUL_W'(filt_q);
      end
      pidfd_pkg::OP_MUL_A2: begin
        mul_a = signed'({{APAD_W{1'b0}}, alpha});
        mul_b = MUL_W'(ud_q);
      end
      pidfd_pkg::OP_NONE, pidfd_pkg::OP_FILT, pidfd_pkg::OP_SUM: begin
        mul_a = '0;
        mul_b = '0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_full = mul_a * mul_b;

  // Integral update and final output clamp
  assign integ_clamp = pidfd_pkg::clamp(
      pidfd_pkg::sat_add(integ_q, pidfd_pkg::fx_scale(prod_q)), integ_upper_q, integ_lower_q);
  assign drive_clamp = pidfd_pkg::clamp(
      pidfd_pkg::sat_add(s1_q, filt_q), out_upper_q, out_lower_q);

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= '0;
      integ_gain_q  <= '0;
      deriv_gain_q  <= '0;
      filt_weight_q <= pidfd_pkg::ALPHA_ONE;
      out_upper_q   <= pidfd_pkg::DATA_MAX;
      out_lower_q   <= pidfd_pkg::DATA_MIN;
      integ_upper_q <= pidfd_pkg::DATA_MAX;
      integ_lower_q <= pidfd_pkg::DATA_MIN;
    end else if (cfg_we_i) begin
      unique case (pidfd_pkg::cfg_reg_e'(cfg_index_i))
        pidfd_pkg::REG_PROP_GAIN:   prop_gain_q   <= signed'(cfg_data_i);
        pidfd_pkg::REG_INTEG_GAIN:  integ_gain_q  <= signed'(cfg_data_i);
        pidfd_pkg::REG_DERIV_GAIN:  deriv_gain_q  <= signed'(cfg_data_i);
        pidfd_pkg::REG_FILT_WEIGHT: filt_weight_q <= cfg_data_i[pidfd_pkg::ALPHA_BITS-1:0];
        pidfd_pkg::REG_OUT_UPPER:   out_upper_q   <= signed'(cfg_data_i);
        pidfd_pkg::REG_OUT_LOWER:   out_lower_q   <= signed'(cfg_data_i);
        pidfd_pkg::REG_INTEG_UPPER: integ_upper_q <= signed'(cfg_data_i);
        pidfd_pkg::REG_INTEG_LOWER: integ_lower_q <= signed'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Loop state: previous error, integral and filtered derivative
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      integ_q    <= '0;
      filt_q     <= '0;
    end else begin
      if (cmd_i.op == pidfd_pkg::OP_MUL_P) begin
        last_err_q <= err_q;
      end
      if (cmd_i.op == pidfd_pkg::OP_MUL_D) begin
        integ_q <= integ_clamp.value;
      end
      if (cmd_i.op == pidfd_pkg::OP_FILT) begin
        filt_q <= pidfd_pkg::sat_wide((acc_q + prod_q) >>> pidfd_pkg::ALPHA_FRAC);
      end
    end
  end

  // Working registers of the multiply sequence
  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[pidfd_pkg::WIDE_WIDTH-1:0];
    if (cmd_i.take_in) begin
      err_q <= pidfd_pkg::sat_sub(setpoint_i, measured_i);
    end
    unique case (cmd_i.op)
      pidfd_pkg::OP_MUL_P:  diff_q <= pidfd_pkg::sat_sub(err_q, last_err_q);
      pidfd_pkg::OP_MUL_I:  prop_q <= pidfd_pkg::fx_scale(prod_q);
      pidfd_pkg::OP_MUL_D:  ihit_q <= integ_clamp.hit;
      pidfd_pkg::OP_MUL_A1: ud_q   <= pidfd_pkg::fx_scale(prod_q);
      pidfd_pkg::OP_MUL_A2: acc_q  <= prod_q;
      pidfd_pkg::OP_FILT:   s1_q   <= pidfd_pkg::sat_add(prop_q, integ_q);
      pidfd_pkg::OP_NONE, pidfd_pkg::OP_SUM: ;
      default: ;
    endcase
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      drive_q    <= drive_clamp.value;
      dhit_q     <= drive_clamp.hit;
      ihit_out_q <= ihit_q;
    end
  end

  assign drive_o         = drive_q;
  assign drive_clamped_o = dhit_q;
  assign integ_clamped_o = ihit_out_q;

endmodule

>>> design/pid_filtered_derivative_clamped.sv
// Top level of the PID controller with filtered derivative and clamped integral.
//
// Each input word (setpoint, measured, signed Q16.16) yields one output word:
// the drive value clamped to out_lower..out_upper, plus flags that mark when
// the output or integral limit was applied. An accepted word has its error
// registered on accept; then seven steps share a single 33 x 33 multiplier
// for the proportional, integral and derivative products and the two
// low-pass filter products, with the final sum and clamp in the last step.
// No new word is accepted before the last step ends. The finished word waits in
// an output register, so a new word is accepted while the previous result is
// still stalled; the last step holds only if the output register is full and
// stalled. Configuration writes are always ready and are meant for idle periods.
module pid_filtered_derivative_clamped (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [pidfd_pkg::DATA_WIDTH-1:0] setpoint_i,
  input  logic signed [pidfd_pkg::DATA_WIDTH-1:0] measured_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [pidfd_pkg::DATA_WIDTH-1:0] drive_o,
  output logic                                    drive_clamped_o,
  output logic                                    integ_clamped_o,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [pidfd_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [pidfd_pkg::DATA_WIDTH-1:0]        cfg_data_i
);

  pidfd_pkg::dp_cmd_t cmd;
  logic               cfg_we;

  // Register writes complete in the cycle they are offered
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  pidfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  pidfd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .setpoint_i      (setpoint_i),
    .measured_i      (measured_i),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .drive_o         (drive_o),
    .drive_clamped_o (drive_clamped_o),
    .integ_clamped_o (integ_clamped_o)
  );

endmodule
